>>> rtl/core/tva_pkg.sv
// tva_pkg: opcodes, tags and fault codes for the tagged value alu
// no dependencies
`default_nettype none
package tva_pkg;
	typedef enum logic [4:0] {
		OP_ADD = 5'd0, OP_SUB = 5'd1, OP_MUL = 5'd2, OP_DIV = 5'd3, OP_MOD = 5'd4,
		OP_EQ = 5'd5, OP_OR = 5'd6, OP_AND = 5'd7, OP_GT = 5'd8, OP_LT = 5'd9,
		OP_GE = 5'd10, OP_LE = 5'd11, OP_BOR = 5'd12, OP_BAND = 5'd13,
		OP_BXOR = 5'd14, OP_SHL = 5'd15, OP_SHR = 5'd16, OP_NOT = 5'd17,
		OP_BNOT = 5'd18
	} op_t;

	typedef enum logic [2:0] {
		TAG_NUMBER = 3'd0, TAG_STRING = 3'd1, TAG_BOOL = 3'd2, TAG_TYPE = 3'd3,
		TAG_CHAR = 3'd4, TAG_PTR = 3'd5, TAG_ARRAY = 3'd6
	} tag_t;

	localparam logic [1:0] FAULT_OK = 2'd0;
	localparam logic [1:0] FAULT_DIV0 = 2'd1;
	localparam logic [1:0] FAULT_STREQ = 2'd2;

	localparam int DW = 32;
endpackage
`default_nettype wire

>>> rtl/core/tagged_value_alu.sv
// tagged_value_alu: typed alu of a stack machine, fixed-latency pipeline
// depends on tva_pkg and tva_divider
//
// channel  | ports                                      | handshake
// request  | req_type type_a value_a type_b value_b     | start, busy
// result   | result_tag result_word fault               | done (one-cycle strobe)
//
// every item passes stage 1, the one-bit-per-stage divider and the output stage
// all ops travel the same pipeline so results leave in order
// one item may enter each cycle; busy is always low
// reset clears only valid bits; payload registers are not reset
`default_nettype none
module tagged_value_alu
	import tva_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [4:0]  req_type,
	input  wire logic [2:0]  type_a,
	input  wire logic [63:0] value_a,
	input  wire logic [2:0]  type_b,
	input  wire logic [63:0] value_b,
	output logic             done,
	output logic [2:0]       result_tag,
	output logic [63:0]      result_word,
	output logic [1:0]       fault
);
	typedef struct packed {
		logic [2:0]  tag;
		logic [31:0] word;
		logic        sext;
		logic [1:0]  flt;
		logic        use_div;
		logic        use_mod;
	} side_t;

	localparam int SW = $bits(side_t);

	assign busy = 1'b0;

	// stage 1: register operands
	logic        v_s1;
	logic [4:0]  op_s1;
	logic [2:0]  ta_s1, tb_s1;
	logic [63:0] va_s1, vb_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		op_s1 <= req_type;
		ta_s1 <= type_a;
		va_s1 <= value_a;
		tb_s1 <= type_b;
		vb_s1 <= value_b;
	end

	// stage 2: all ops except div/mod, and the low product
	logic [31:0] a32, b32;
	logic        nums, bools, ordered;
	logic signed [31:0] sa, sb;
	side_t       sd;
	logic [31:0] prod;

	assign a32 = va_s1[31:0];
	assign b32 = vb_s1[31:0];
	assign sa = a32;
	assign sb = b32;
	assign nums = (ta_s1 == TAG_NUMBER) && (tb_s1 == TAG_NUMBER);
	assign bools = (ta_s1 == TAG_BOOL) && (tb_s1 == TAG_BOOL);
	assign prod = a32 * b32;

	always_comb begin
		logic lt, gt;
		ordered = (ta_s1 == tb_s1) && (ta_s1 == TAG_NUMBER || ta_s1 == TAG_CHAR);
		if (ta_s1 == TAG_NUMBER) begin
			lt = sa < sb;
			gt = sa > sb;
		end else begin
			lt = va_s1[7:0] < vb_s1[7:0];
			gt = va_s1[7:0] > vb_s1[7:0];
		end
		sd = '{tag: TAG_NUMBER, word: 32'd0, sext: 1'b0, flt: FAULT_OK,
			use_div: 1'b0, use_mod: 1'b0};
		case (op_s1)
			OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
				sd.tag = ta_s1;
				if (nums) begin
					sd.tag = TAG_NUMBER;
					sd.sext = 1'b1;
					case (op_s1)
						OP_ADD: sd.word = a32 + b32;
						OP_SUB: sd.word = a32 - b32;
						OP_MUL: sd.word = prod;
						default: begin
							if (b32 == 32'd0) sd.flt = FAULT_DIV0;
							else if (op_s1 == OP_DIV) sd.use_div = 1'b1;
							else sd.use_mod = 1'b1;
						end
					endcase
				end
			end
			OP_EQ: begin
				sd.tag = TAG_BOOL;
				if (ta_s1 == tb_s1) begin
					case (ta_s1)
						TAG_NUMBER: sd.word = {31'd0, a32 == b32};
						TAG_STRING: sd.flt = FAULT_STREQ;
						TAG_BOOL, TAG_CHAR: sd.word = {31'd0, va_s1[7:0] == vb_s1[7:0]};
						TAG_TYPE: sd.word = 32'd1;
						TAG_PTR, TAG_ARRAY: sd.word = {31'd0, va_s1 == vb_s1};
						default: sd.word = 32'd0;
					endcase
				end
			end
			OP_OR: begin
				sd.tag = TAG_BOOL;
				sd.word = {31'd0, bools && ((|va_s1[7:0]) || (|vb_s1[7:0]))};
			end
			OP_AND: begin
				sd.tag = TAG_BOOL;
				sd.word = {31'd0, bools && (|va_s1[7:0]) && (|vb_s1[7:0])};
			end
			OP_GT: begin sd.tag = TAG_BOOL; sd.word = {31'd0, ordered && gt}; end
			OP_LT: begin sd.tag = TAG_BOOL; sd.word = {31'd0, ordered && lt}; end
			OP_GE: begin sd.tag = TAG_BOOL; sd.word = {31'd0, ordered && !lt}; end
			OP_LE: begin sd.tag = TAG_BOOL; sd.word = {31'd0, ordered && !gt}; end
			OP_BOR, OP_BAND, OP_BXOR, OP_SHL, OP_SHR: begin
				if (nums) begin
					sd.sext = 1'b1;
					case (op_s1)
						OP_BOR: sd.word = a32 | b32;
						OP_BAND: sd.word = a32 & b32;
						OP_BXOR: sd.word = a32 ^ b32;
						OP_SHL: sd.word = a32 << b32[4:0];
						default: sd.word = 32'(sa >>> b32[4:0]);
					endcase
				end
			end
			OP_NOT: begin
				sd.tag = TAG_BOOL;
				sd.word = {31'd0, (ta_s1 == TAG_BOOL) && (va_s1[7:0] == 8'd0)};
			end
			OP_BNOT: begin
				if (ta_s1 == TAG_NUMBER) begin
					sd.sext = 1'b1;
					sd.word = ~a32;
				end
			end
			default: sd.word = 32'd0;
		endcase
	end

	// divider carries the rest of the item as side data
	logic        dv_valid;
	logic [31:0] dv_q, dv_r;
	side_t       dv_side;
	logic [SW-1:0] dv_side_bits;

	tva_divider #(.SIDE_W(SW)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s1),
		.dividend  (a32),
		.divisor   (b32),
		.side_in   (sd),
		.out_valid (dv_valid),
		.quotient  (dv_q),
		.remainder (dv_r),
		.side_out  (dv_side_bits)
	);
	assign dv_side = side_t'(dv_side_bits);

	// output stage: merge divider result and sign-extend
	logic [31:0] fin;
	always_comb begin
		if (dv_side.use_div) fin = dv_q;
		else if (dv_side.use_mod) fin = dv_r;
		else fin = dv_side.word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		result_tag  <= dv_side.tag;
		result_word <= {(dv_side.sext && fin[31]) ? 32'hFFFF_FFFF : 32'd0, fin};
		fault       <= dv_side.flt;
	end
endmodule
`default_nettype wire

>>> rtl/core/tva_divider.sv
// tva_divider: pipelined signed 32-bit divider, one quotient bit per stage
// depends on tva_pkg; carries a side word alongside each item
`default_nettype none
module tva_divider
	import tva_pkg::*;
#(
	parameter int SIDE_W = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	input  wire logic [DW-1:0]     dividend,
	input  wire logic [DW-1:0]     divisor,
	input  wire logic [SIDE_W-1:0] side_in,
	output logic                   out_valid,
	output logic [DW-1:0]          quotient,
	output logic [DW-1:0]          remainder,
	output logic [SIDE_W-1:0]      side_out
);
	// stage 0 holds magnitudes, stages 1..DW do one restoring step each
	logic [DW:0]       vld_q;
	logic [DW-1:0]     rem_q  [DW+1];
	logic [DW-1:0]     quo_q  [DW+1];
	logic [DW-1:0]     dvs_q  [DW+1];
	logic              nq_q   [DW+1];
	logic              nr_q   [DW+1];
	logic [SIDE_W-1:0] side_q [DW+1];

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[DW-1:0], in_valid};
		end
	end

	// magnitude and sign capture
	always_ff @(posedge clk) begin
		rem_q[0]  <= '0;
		quo_q[0]  <= dividend[DW-1] ? (~dividend + 1'b1) : dividend;
		dvs_q[0]  <= divisor[DW-1] ? (~divisor + 1'b1) : divisor;
		nq_q[0]   <= dividend[DW-1] ^ divisor[DW-1];
		nr_q[0]   <= dividend[DW-1];
		side_q[0] <= side_in;
	end

	// restoring steps
	for (genvar i = 0; i < DW; i++) begin : g_step
		logic [DW:0] trial;
		logic [DW:0] diff;
		assign trial = {rem_q[i], quo_q[i][DW-1]};
		assign diff  = trial - {1'b0, dvs_q[i]};
		always_ff @(posedge clk) begin
			rem_q[i+1]  <= diff[DW] ? trial[DW-1:0] : diff[DW-1:0];
			quo_q[i+1]  <= {quo_q[i][DW-2:0], ~diff[DW]};
			dvs_q[i+1]  <= dvs_q[i];
			nq_q[i+1]   <= nq_q[i];
			nr_q[i+1]   <= nr_q[i];
			side_q[i+1] <= side_q[i];
		end
	end

	assign out_valid = vld_q[DW];
	assign quotient  = nq_q[DW] ? (~quo_q[DW] + 1'b1) : quo_q[DW];
	assign remainder = nr_q[DW] ? (~rem_q[DW] + 1'b1) : rem_q[DW];
	assign side_out  = side_q[DW];
endmodule
`default_nettype wire
